### rtl/core/tgen_pkg.sv
package tgen_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = 10;
  localparam int SUM_W        = 48;
  localparam int DIV_NUM_W    = 64;
  localparam int DIV_DEN_W    = 48;
  localparam int SQ_W         = 64;
  localparam int ROOT_W       = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_TRIANGLE = 2'd1,
    CMD_READ     = 2'd2
  } cmd_t;

  // per-vertex attribute record, element 0 is x
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][15:0] norm;
    logic [31:0]      tex_u;
    logic [31:0]      tex_v;
  } vert_t;

  // per-vertex tangent sum, Q32.16
  typedef logic [2:0][SUM_W-1:0] sum_t;

  typedef struct packed {
    logic                 wide;
    logic signed [31:0]   a;
    logic signed [31:0]   b;
    logic signed [15:0]   n;
    logic signed [47:0]   w;
  } mul_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic idx_ok(input logic [VIDX_W-1:0] idx);
    return (32'(idx) < MAX_VERTICES);
  endfunction

  // difference saturated to signed 32 bits
  function automatic logic signed [31:0] sub_sat32(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
    logic signed [32:0] d;
    d = 33'(x) - 33'(y);
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return d[31:0];
  endfunction

  // signed 49 bits saturated to 48
  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    if (x[48] != x[47]) begin
      return x[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return x[47:0];
  endfunction

  // signed 52 bits clamped to 48
  function automatic logic signed [47:0] clamp48(input logic signed [51:0] x);
    if ((x[51:47] != 5'b00000) && (x[51:47] != 5'b11111)) begin
      return x[51] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return x[47:0];
  endfunction

  // magnitude of a value known to stay within 48 bits
  function automatic logic [47:0] abs49(input logic signed [48:0] x);
    logic [48:0] m;
    m = x[48] ? 49'(-x) : 49'(x);
    return m[47:0];
  endfunction

endpackage

### rtl/core/tgen_if.sv
interface tgen_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         corner_a;
  logic [9:0]         corner_b;
  logic [9:0]         corner_c;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;

  modport source (output valid, command, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                  norm_x, norm_y, norm_z, tex_u, tex_v, input ready);
  modport sink (input valid, command, corner_a, corner_b, corner_c, pos_x, pos_y, pos_z,
                norm_x, norm_y, norm_z, tex_u, tex_v, output ready);
endinterface

interface tgen_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         vertex_id;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_y;
  logic signed [15:0] tangent_z;
  logic               tangent_zero;
  logic               skipped_seen;

  modport source (output valid, vertex_id, tangent_x, tangent_y, tangent_z, tangent_zero,
                  skipped_seen, input ready);
  modport sink (input valid, vertex_id, tangent_x, tangent_y, tangent_z, tangent_zero,
                skipped_seen, output ready);
endinterface

### rtl/core/tgen_mul.sv
module tgen_mul import tgen_pkg::*; (
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [63:0] prod_r
);

  logic signed [63:0] prod_narrow;
  logic signed [63:0] prod_wide;

  // 32x32 for triangle terms and squares, 16x48 for normal projections
  always_comb begin
    prod_narrow = 64'(req.a) * 64'(req.b);
    prod_wide   = 64'(req.n) * 64'(req.w);
  end

  always_ff @(posedge clk) begin
    prod_r <= req.wide ? prod_wide : prod_narrow;
  end

endmodule

### rtl/core/tgen_div.sv
module tgen_div import tgen_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [5:0]           cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W+1:0] rem_sh;
  logic                 fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
    fits   = (rem_sh >= {2'b00, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_NUM_W - 1);
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? (DIV_DEN_W+1)'(rem_sh - {2'b00, den_r})
                      : (DIV_DEN_W+1)'(rem_sh);
        quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
        num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### rtl/core/tgen_sqrt.sv
module tgen_sqrt import tgen_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic            busy_r;
  logic            done_r;
  logic [4:0]      cnt_r;
  logic [SQ_W-1:0] x_r;
  logic [SQ_W-1:0] r_r;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] trial;

  assign trial = r_r + bit_r;

  // digit-by-digit integer root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(ROOT_W - 1);
        x_r    <= req.rad;
        r_r    <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = r_r[ROOT_W-1:0];

endmodule

### rtl/core/mesh_tangent_generator.sv
// Per-vertex tangent generator for triangle meshes.
// in_chan takes command words: load stores a vertex's position, normal and
// texture coordinate and clears its tangent sum; triangle adds the UV-weighted
// edge tangent to the sums of its three corners; read projects out the normal,
// normalizes and returns one word on out_chan. Load and triangle give no word.
// Words addressing vertices outside the table, or with an unknown command,
// are dropped without effect.
// One word is worked on at a time; in_chan.ready is high only while idle.
// A load is done at its accept. A triangle keeps the input blocked through
// the three corner fetches, the product sequence, three passes of the shared
// bit-serial divider and the three read-modify-writes of the sum memory; it
// returns to idle after the products when the UV determinant is zero. A read
// blocks through the projection, the normalizing shifts, the square sums, the
// root and three divider passes.
// The result waits in an output register; a stalled receiver holds it there
// while the next command word is already accepted, and the block stops only
// when a second read result is ready before the first was taken.
// Reset clears the control state and the skipped-triangle flag; vertex data
// and sums are undefined until loaded.
module mesh_tangent_generator import tgen_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tgen_in_if.sink    in_chan,
  tgen_out_if.source out_chan
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_TRI_A, ST_TRI_B, ST_TRI_C, ST_TRI_MUL, ST_TRI_CHK, ST_TRI_DIV, ST_TRI_DWT,
    ST_SUM_RD, ST_SUM_WR, ST_RD_LD, ST_RD_MUL, ST_RD_NORM, ST_RD_SQ, ST_RD_SQRT, ST_RD_SWT,
    ST_RD_DIV, ST_RD_DWT, ST_RD_OUT
  } state_t;

  state_t state_r;

  vert_t vert_mem [MAX_VERTICES];
  sum_t  sum_mem  [MAX_VERTICES];
  vert_t vdata_r;
  sum_t  sdata_r;

  logic              in_acc;
  logic              vwr_en;
  vert_t             vwr_data;
  logic              swr_en;
  logic [VIDX_W-1:0] swr_addr;
  sum_t              swr_data;
  logic [VIDX_W-1:0] vaddr;
  logic [VIDX_W-1:0] saddr;
  logic [VIDX_W-1:0] corner_j;

  logic [VIDX_W-1:0]  ca_r, cb_r, cc_r;
  logic [1:0]         k_r;
  logic [3:0]         mstep_r;
  logic signed [31:0] apos_r [3];
  logic signed [31:0] au_r, av_r;
  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [47:0] acc_r;
  logic signed [48:0] det_r;
  logic signed [48:0] n_r [3];
  logic signed [47:0] t_r [3];
  logic signed [15:0] nrm_r [3];
  logic signed [47:0] tsum_r [3];
  logic signed [51:0] d_r;
  logic [50:0]        mag_r [3];
  logic               rneg_r [3];
  logic [SQ_W-1:0]    sq_r;
  logic [ROOT_W-1:0]  len_r;
  logic signed [15:0] tan_r [3];
  logic               zero_r;
  logic               skip_r;

  logic               out_valid_r;
  logic [9:0]         out_vid_r;
  logic signed [15:0] out_tan_r [3];
  logic               out_zero_r;
  logic               out_skip_r;

  mul_req_t           mul_req;
  logic signed [63:0] prod_r;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  sqrt_req_t          sqrt_req;
  sqrt_rsp_t          sqrt_rsp;

  logic signed [47:0] psh16;
  logic signed [49:0] psh14;
  logic [2:0]         tri_i;
  logic [1:0]         coll;
  logic [1:0]         coll_s;
  logic [1:0]         pair;
  logic [1:0]         mix;
  logic signed [48:0] tri_diff;
  logic signed [50:0] rdiff;
  logic [50:0]        rd_mag;
  logic [50:0]        mx;
  logic signed [47:0] dclamp;
  logic signed [47:0] t_new;
  logic signed [15:0] tan_new;
  logic [47:0]        det_abs;
  logic [47:0]        n_abs;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  // corner under update
  always_comb begin
    unique case (k_r)
      2'd0:    corner_j = ca_r;
      2'd1:    corner_j = cb_r;
      default: corner_j = cc_r;
    endcase
  end

  // memory addresses
  always_comb begin
    unique case (state_r)
      ST_IDLE:  vaddr = in_chan.corner_a;
      ST_TRI_A: vaddr = cb_r;
      ST_TRI_B: vaddr = cc_r;
      default:  vaddr = ca_r;
    endcase
    saddr = (state_r == ST_IDLE) ? in_chan.corner_a : corner_j;
  end

  // load writes attributes and clears the sum; a triangle adds its saturated term
  always_comb begin
    vwr_en         = in_acc && (in_chan.command == CMD_LOAD) && idx_ok(in_chan.corner_a);
    vwr_data.pos   = {in_chan.pos_z, in_chan.pos_y, in_chan.pos_x};
    vwr_data.norm  = {in_chan.norm_z, in_chan.norm_y, in_chan.norm_x};
    vwr_data.tex_u = in_chan.tex_u;
    vwr_data.tex_v = in_chan.tex_v;
    swr_en   = vwr_en || (state_r == ST_SUM_WR);
    swr_addr = vwr_en ? in_chan.corner_a : corner_j;
    for (int k = 0; k < 3; k++) begin
      swr_data[k] = vwr_en ? '0
                           : sat48(49'($signed(sdata_r[k])) + 49'(t_r[k]));
    end
  end

  // vertex attribute memory
  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vert_mem[in_chan.corner_a] <= vwr_data;
    end
    vdata_r <= vert_mem[vaddr];
  end

  // tangent sum memory
  always_ff @(posedge clk) begin
    if (swr_en) begin
      sum_mem[swr_addr] <= swr_data;
    end
    sdata_r <= sum_mem[saddr];
  end

  // product alignment, sequencing indexes, differences and magnitudes
  always_comb begin
    psh16    = prod_r[63:16];
    psh14    = prod_r[63:14];
    tri_i    = 3'(mstep_r - 4'd1);
    coll     = 2'(mstep_r - 4'd1);
    coll_s   = (coll == 2'd3) ? 2'd0 : coll;
    pair     = mstep_r[2:1];
    mix      = (mstep_r[1:0] == 2'd3) ? 2'd0 : mstep_r[1:0];
    tri_diff = 49'(acc_r) - 49'(psh16);
    rdiff    = 51'(tsum_r[coll_s]) - 51'(psh14);
    rd_mag   = rdiff[50] ? 51'(-rdiff) : 51'(rdiff);
    dclamp   = clamp48(d_r);
    mx       = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    mx       = (mag_r[2] > mx) ? mag_r[2] : mx;
    det_abs  = abs49(det_r);
    n_abs    = abs49(n_r[k_r]);
  end

  // quotient to signed tangent term, saturated, and to the signed result component
  always_comb begin
    if (n_r[k_r][48] ^ det_r[48]) begin
      t_new = (div_rsp.quo > 64'h0000_8000_0000_0000) ? 48'sh8000_0000_0000
                                                     : 48'(48'd0 - div_rsp.quo[47:0]);
    end else begin
      t_new = (div_rsp.quo > 64'h0000_7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF
                                                     : div_rsp.quo[47:0];
    end
    tan_new = rneg_r[k_r] ? 16'(16'd0 - div_rsp.quo[15:0]) : div_rsp.quo[15:0];
  end

  // multiplier operands
  always_comb begin
    mul_req      = '0;
    mul_req.wide = (state_r == ST_RD_MUL);
    unique case (state_r)
      ST_TRI_MUL: begin
        if (pair == 2'd0) begin
          mul_req.a = mstep_r[0] ? du2_r : du1_r;
          mul_req.b = mstep_r[0] ? dv1_r : dv2_r;
        end else begin
          mul_req.a = mstep_r[0] ? dv1_r : dv2_r;
          mul_req.b = mstep_r[0] ? e2_r[pair - 2'd1] : e1_r[pair - 2'd1];
        end
      end
      ST_RD_MUL: begin
        mul_req.n = nrm_r[mix];
        mul_req.w = mstep_r[2] ? dclamp : tsum_r[mix];
      end
      ST_RD_SQ: begin
        mul_req.a = $signed({2'b00, mag_r[mix][29:0]});
        mul_req.b = $signed({2'b00, mag_r[mix][29:0]});
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  // divider and root operands
  always_comb begin
    div_req.start = (state_r == ST_TRI_DIV) || (state_r == ST_RD_DIV);
    if (state_r == ST_RD_DIV) begin
      div_req.num = {20'd0, mag_r[k_r][29:0], 14'd0} + 64'(len_r[ROOT_W-1:1]);
      div_req.den = 48'(len_r);
    end else begin
      div_req.num = {n_abs, 16'd0};
      div_req.den = det_abs;
    end
    sqrt_req.start = (state_r == ST_RD_SQRT);
    sqrt_req.rad   = sq_r;
  end

  tgen_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  tgen_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tgen_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // command sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      skip_r      <= 1'b0;
    end else begin
      // the output state handles its own handoff
      if (out_valid_r && out_chan.ready && (state_r != ST_RD_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ca_r <= in_chan.corner_a;
            cb_r <= in_chan.corner_b;
            cc_r <= in_chan.corner_c;
            if ((in_chan.command == CMD_TRIANGLE) && idx_ok(in_chan.corner_a) &&
                idx_ok(in_chan.corner_b) && idx_ok(in_chan.corner_c)) begin
              state_r <= ST_TRI_A;
            end else if ((in_chan.command == CMD_READ) && idx_ok(in_chan.corner_a)) begin
              state_r <= ST_RD_LD;
            end
          end
        end
        ST_TRI_A: begin
          for (int k = 0; k < 3; k++) begin
            apos_r[k] <= vdata_r.pos[k];
          end
          au_r    <= vdata_r.tex_u;
          av_r    <= vdata_r.tex_v;
          state_r <= ST_TRI_B;
        end
        ST_TRI_B: begin
          for (int k = 0; k < 3; k++) begin
            e1_r[k] <= sub_sat32(vdata_r.pos[k], apos_r[k]);
          end
          du1_r   <= sub_sat32(vdata_r.tex_u, au_r);
          dv1_r   <= sub_sat32(vdata_r.tex_v, av_r);
          state_r <= ST_TRI_C;
        end
        ST_TRI_C: begin
          for (int k = 0; k < 3; k++) begin
            e2_r[k] <= sub_sat32(vdata_r.pos[k], apos_r[k]);
          end
          du2_r   <= sub_sat32(vdata_r.tex_u, au_r);
          dv2_r   <= sub_sat32(vdata_r.tex_v, av_r);
          mstep_r <= '0;
          state_r <= ST_TRI_MUL;
        end
        ST_TRI_MUL: begin
          // products pair up as determinant, then numerators x, y, z
          if (mstep_r != 4'd0) begin
            if (!tri_i[0]) begin
              acc_r <= psh16;
            end else if (tri_i[2:1] == 2'd0) begin
              det_r <= tri_diff;
            end else begin
              n_r[tri_i[2:1] - 2'd1] <= tri_diff;
            end
          end
          if (mstep_r == 4'd8) begin
            state_r <= ST_TRI_CHK;
          end else begin
            mstep_r <= mstep_r + 4'd1;
          end
        end
        ST_TRI_CHK: begin
          k_r <= '0;
          if (det_r == '0) begin
            skip_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_TRI_DIV;
          end
        end
        ST_TRI_DIV: begin
          state_r <= ST_TRI_DWT;
        end
        ST_TRI_DWT: begin
          if (div_rsp.done) begin
            t_r[k_r] <= t_new;
            if (k_r == 2'd2) begin
              k_r     <= '0;
              state_r <= ST_SUM_RD;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_TRI_DIV;
            end
          end
        end
        ST_SUM_RD: begin
          state_r <= ST_SUM_WR;
        end
        ST_SUM_WR: begin
          // repeated corners see the previous write on the next read
          if (k_r == 2'd2) begin
            state_r <= ST_IDLE;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= ST_SUM_RD;
          end
        end
        ST_RD_LD: begin
          for (int k = 0; k < 3; k++) begin
            nrm_r[k]  <= $signed(vdata_r.norm[k]);
            tsum_r[k] <= $signed(sdata_r[k]);
          end
          d_r     <= '0;
          mstep_r <= '0;
          state_r <= ST_RD_MUL;
        end
        ST_RD_MUL: begin
          // normal dot sum first, then the projection per axis
          if ((mstep_r >= 4'd1) && (mstep_r <= 4'd3)) begin
            d_r <= d_r + 52'(psh14);
          end
          if (mstep_r >= 4'd5) begin
            mag_r[coll_s]  <= rd_mag;
            rneg_r[coll_s] <= rdiff[50];
          end
          if (mstep_r == 4'd7) begin
            state_r <= ST_RD_NORM;
          end else begin
            mstep_r <= mstep_r + 4'd1;
          end
        end
        ST_RD_NORM: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx == '0) begin
            zero_r <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              tan_r[k] <= '0;
            end
            state_r <= ST_RD_OUT;
          end else if (mx[50:30] != '0) begin
            for (int k = 0; k < 3; k++) begin
              mag_r[k] <= mag_r[k] >> 1;
            end
          end else if (!mx[29]) begin
            for (int k = 0; k < 3; k++) begin
              mag_r[k] <= mag_r[k] << 1;
            end
          end else begin
            mstep_r <= '0;
            sq_r    <= '0;
            state_r <= ST_RD_SQ;
          end
        end
        ST_RD_SQ: begin
          if (mstep_r != 4'd0) begin
            sq_r <= sq_r + SQ_W'(prod_r);
          end
          if (mstep_r == 4'd3) begin
            state_r <= ST_RD_SQRT;
          end else begin
            mstep_r <= mstep_r + 4'd1;
          end
        end
        ST_RD_SQRT: begin
          state_r <= ST_RD_SWT;
        end
        ST_RD_SWT: begin
          if (sqrt_rsp.done) begin
            len_r   <= sqrt_rsp.root;
            k_r     <= '0;
            state_r <= ST_RD_DIV;
          end
        end
        ST_RD_DIV: begin
          state_r <= ST_RD_DWT;
        end
        ST_RD_DWT: begin
          if (div_rsp.done) begin
            tan_r[k_r] <= tan_new;
            if (k_r == 2'd2) begin
              zero_r  <= 1'b0;
              state_r <= ST_RD_OUT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_RD_DIV;
            end
          end
        end
        ST_RD_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_vid_r   <= ca_r;
            for (int k = 0; k < 3; k++) begin
              out_tan_r[k] <= tan_r[k];
            end
            out_zero_r <= zero_r;
            out_skip_r <= skip_r;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.vertex_id    = out_vid_r;
  assign out_chan.tangent_x    = out_tan_r[0];
  assign out_chan.tangent_y    = out_tan_r[1];
  assign out_chan.tangent_z    = out_tan_r[2];
  assign out_chan.tangent_zero = out_zero_r;
  assign out_chan.skipped_seen = out_skip_r;

endmodule

### rtl/core/tgen_checker.sv
module tgen_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  out_vertex_id,
  input logic [15:0] out_tangent_x,
  input logic [15:0] out_tangent_y,
  input logic [15:0] out_tangent_z,
  input logic        out_tangent_zero,
  input logic        out_skipped_seen
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_vertex_id, out_tangent_x, out_tangent_y, out_tangent_z,
               out_tangent_zero, out_skipped_seen}))
    else $error("result word changed while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // zero-length tangent reports all zero components
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tangent_zero |->
      (out_tangent_x == 16'd0) && (out_tangent_y == 16'd0) && (out_tangent_z == 16'd0))
    else $error("zero tangent with nonzero component");

  // a command word cannot produce a result in the following cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

endmodule

bind mesh_tangent_generator tgen_checker u_tgen_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_vertex_id    (out_chan.vertex_id),
  .out_tangent_x    (out_chan.tangent_x),
  .out_tangent_y    (out_chan.tangent_y),
  .out_tangent_z    (out_chan.tangent_z),
  .out_tangent_zero (out_chan.tangent_zero),
  .out_skipped_seen (out_chan.skipped_seen)
);
